@@ hw/rtl/shps_pkg.sv @@
`default_nettype none
package shps_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_HOLD_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_REST_WIDTH_C = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_PERIOD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAP_ONE      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAP_TWO      = 3'd4;

  // Register reset values
  localparam logic [7:0] HOLD_WIDTH_RST   = 8'd224;
  localparam logic [7:0] REST_WIDTH_C_RST = 8'd126;
  localparam logic [7:0] BASE_PERIOD_RST  = 8'd25;
  localparam logic [7:0] GAP_ONE_RST      = 8'd5;
  localparam logic [7:0] GAP_TWO_RST      = 8'd8;

  // Phase counter starts at the top so the first frame wraps
  localparam logic [7:0] PHASE_RST = 8'hFF;
  localparam logic [7:0] WIDTH_MAX = 8'hFF;

  // One quotient bit per divider step
  localparam int unsigned DIV_STEPS = 8;

  // Reciprocal constants for speed/9 and speed/3 (speed is 7 bits)
  localparam logic [5:0] RECIP_NINE  = 6'd57;
  localparam logic [7:0] RECIP_THREE = 8'd171;
  localparam int unsigned RECIP_SHIFT = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_SWING,
    ST_WRAP1,
    ST_WRAP2,
    ST_WRAP3
  } shps_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture result and sample
    logic div_init;
    logic div_step;
    logic lookup;
    logic swing;
    logic win_two;
    logic win_three;
    logic wrap_one;
    logic wrap_two;
    logic wrap_three;
  } shps_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_valid;
    logic lt_one;
    logic lt_two;
    logic lt_three;
    logic div_last;
  } shps_sts_t;

  // Quarter-sine table
  localparam logic [7:0] QSINE [0:255] = '{
    8'd0, 8'd2, 8'd3, 8'd5, 8'd6, 8'd8, 8'd9, 8'd11,
    8'd13, 8'd14, 8'd16, 8'd17, 8'd19, 8'd20, 8'd22, 8'd23,
    8'd25, 8'd27, 8'd28, 8'd30, 8'd31, 8'd33, 8'd34, 8'd36,
    8'd37, 8'd39, 8'd41, 8'd42, 8'd44, 8'd45, 8'd47, 8'd48,
    8'd50, 8'd51, 8'd53, 8'd54, 8'd56, 8'd57, 8'd59, 8'd60,
    8'd62, 8'd63, 8'd65, 8'd67, 8'd68, 8'd70, 8'd71, 8'd73,
    8'd74, 8'd76, 8'd77, 8'd79, 8'd80, 8'd81, 8'd83, 8'd84,
    8'd86, 8'd87, 8'd89, 8'd90, 8'd92, 8'd93, 8'd95, 8'd96,
    8'd98, 8'd99, 8'd100, 8'd102, 8'd103, 8'd105, 8'd106, 8'd108,
    8'd109, 8'd110, 8'd112, 8'd113, 8'd115, 8'd116, 8'd117, 8'd119,
    8'd120, 8'd122, 8'd123, 8'd124, 8'd126, 8'd127, 8'd128, 8'd130,
    8'd131, 8'd132, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139, 8'd140,
    8'd142, 8'd143, 8'd144, 8'd146, 8'd147, 8'd148, 8'd149, 8'd151,
    8'd152, 8'd153, 8'd154, 8'd156, 8'd157, 8'd158, 8'd159, 8'd161,
    8'd162, 8'd163, 8'd164, 8'd165, 8'd167, 8'd168, 8'd169, 8'd170,
    8'd171, 8'd172, 8'd174, 8'd175, 8'd176, 8'd177, 8'd178, 8'd179,
    8'd180, 8'd181, 8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188,
    8'd189, 8'd190, 8'd191, 8'd192, 8'd193, 8'd194, 8'd195, 8'd196,
    8'd197, 8'd198, 8'd199, 8'd200, 8'd201, 8'd202, 8'd203, 8'd204,
    8'd205, 8'd206, 8'd207, 8'd208, 8'd208, 8'd209, 8'd210, 8'd211,
    8'd212, 8'd213, 8'd214, 8'd215, 8'd215, 8'd216, 8'd217, 8'd218,
    8'd219, 8'd220, 8'd220, 8'd221, 8'd222, 8'd223, 8'd223, 8'd224,
    8'd225, 8'd226, 8'd226, 8'd227, 8'd228, 8'd228, 8'd229, 8'd230,
    8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234, 8'd235,
    8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239, 8'd240,
    8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244,
    8'd244, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247,
    8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd250,
    8'd250, 8'd250, 8'd251, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252,
    8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

endpackage
`default_nettype wire

@@ hw/rtl/shps_ctrl.sv @@
`default_nettype none
module shps_ctrl
  import shps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      out_tready,
  input  wire shps_sts_t sts,
  output shps_cmd_t      cmd
);

  shps_state_t state_r;
  shps_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Take a new frame when idle and the output slot is empty or frees up this cycle
  assign in_tready = (state_r == ST_IDLE) && (!sts.out_valid || out_tready);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load = 1'b1;
          if (sts.lt_one) begin
            cmd.div_init = 1'b1;
            state_nxt    = ST_DIV;
          end else if (sts.lt_two) begin
            cmd.win_two = 1'b1;
          end else if (sts.lt_three) begin
            cmd.win_three = 1'b1;
          end else begin
            state_nxt = ST_WRAP1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_SWING;
      end
      ST_SWING: begin
        cmd.swing = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_WRAP1: begin
        cmd.wrap_one = 1'b1;
        state_nxt    = ST_WRAP2;
      end
      ST_WRAP2: begin
        cmd.wrap_two = 1'b1;
        state_nxt    = ST_WRAP3;
      end
      ST_WRAP3: begin
        cmd.wrap_three = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/shps_dp.sv @@
`default_nettype none
module shps_dp
  import shps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire shps_cmd_t          cmd,
  output shps_sts_t               sts,
  input  wire logic [7:0]         adc_sample,
  input  wire logic               out_tready,
  output logic                    out_valid,
  output logic                    pulse_valid,
  output logic [7:0]              width_a,
  output logic [7:0]              width_b,
  output logic [7:0]              width_c,
  input  wire logic               cfg_valid,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]         cfg_data
);

  // Configuration registers
  logic [7:0] hold_width_r, rest_width_c_r, base_period_r, gap_one_r, gap_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_width_r   <= HOLD_WIDTH_RST;
      rest_width_c_r <= REST_WIDTH_C_RST;
      base_period_r  <= BASE_PERIOD_RST;
      gap_one_r      <= GAP_ONE_RST;
      gap_two_r      <= GAP_TWO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_WIDTH:   hold_width_r   <= cfg_data;
        REG_REST_WIDTH_C: rest_width_c_r <= cfg_data;
        REG_BASE_PERIOD:  base_period_r  <= cfg_data;
        REG_GAP_ONE:      gap_one_r      <= cfg_data;
        REG_GAP_TWO:      gap_two_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [7:0] phase_r, phase_nxt;
  logic [7:0] lim1_r, lim1_nxt, lim2_r, lim2_nxt, lim3_r, lim3_nxt;
  logic [7:0] cur_a_r, cur_a_nxt, cur_b_r, cur_b_nxt, cur_c_r, cur_c_nxt;

  // Working registers: sample, divider, table value
  logic [7:0] sample_r;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] sine_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic       pulse_r;
  logic [7:0] out_a_r, out_b_r, out_c_r;

  // Divider step: 256*phase/limit_one, one quotient bit per cycle
  logic [8:0] rem_sh;
  logic       rem_ge;
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, lim1_r};

  // Swing widths
  logic [7:0] half, quarter;
  logic [8:0] c_sum;
  assign half    = {1'b0, sine_r[7:1]};
  assign quarter = {2'b00, sine_r[7:2]};
  assign c_sum   = {1'b0, rest_width_c_r} + {1'b0, quarter};

  // Limit sums at wrap
  logic [6:0]  speed;
  logic [12:0] prod_nine;
  logic [14:0] prod_three;
  logic [3:0]  speed_div9;
  logic [5:0]  speed_div3;
  logic [8:0]  sum_one;
  logic [9:0]  sum_two, sum_three;

  assign speed      = sample_r[7:1];
  assign prod_nine  = speed * RECIP_NINE;
  assign prod_three = speed * RECIP_THREE;
  assign speed_div9 = prod_nine[RECIP_SHIFT +: 4];
  assign speed_div3 = prod_three[RECIP_SHIFT +: 6];
  assign sum_one    = {1'b0, base_period_r} + {2'b00, speed};
  assign sum_two    = {2'b00, lim1_r} + {2'b00, gap_one_r} + {6'd0, speed_div9};
  assign sum_three  = {2'b00, lim2_r} + {2'b00, gap_two_r} + {4'd0, speed_div3};

  always_comb begin
    phase_nxt     = phase_r;
    lim1_nxt      = lim1_r;
    lim2_nxt      = lim2_r;
    lim3_nxt      = lim3_r;
    cur_a_nxt     = cur_a_r;
    cur_b_nxt     = cur_b_r;
    cur_c_nxt     = cur_c_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;

    // Result slot
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.div_init) begin
      rem_nxt = phase_r;
      quo_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = rem_ge ? 8'(rem_sh - {1'b0, lim1_r}) : rem_sh[7:0];
      quo_nxt = {quo_r[6:0], rem_ge};
      cnt_nxt = cnt_r + 3'd1;
    end

    // Swing window
    if (cmd.swing) begin
      cur_a_nxt = (hold_width_r > half) ? 8'(hold_width_r - half) : 8'd0;
      cur_b_nxt = cur_a_nxt;
      cur_c_nxt = c_sum[8] ? WIDTH_MAX : c_sum[7:0];
      phase_nxt = phase_r + 8'd1;
    end
    // Hold windows
    if (cmd.win_two) begin
      cur_a_nxt = hold_width_r;
      cur_c_nxt = rest_width_c_r;
      phase_nxt = phase_r + 8'd1;
    end
    if (cmd.win_three) begin
      cur_b_nxt = hold_width_r;
      phase_nxt = phase_r + 8'd1;
    end

    // Wrap: new limits, one per cycle
    if (cmd.wrap_one) begin
      lim1_nxt  = sum_one[8] ? WIDTH_MAX : sum_one[7:0];
      phase_nxt = 8'd1;
    end
    if (cmd.wrap_two) begin
      lim2_nxt = (sum_two[9:8] != 2'b00) ? WIDTH_MAX : sum_two[7:0];
    end
    if (cmd.wrap_three) begin
      lim3_nxt = (sum_three[9:8] != 2'b00) ? WIDTH_MAX : sum_three[7:0];
    end
  end

  // State with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_RST;
      lim1_r      <= '0;
      lim2_r      <= '0;
      lim3_r      <= '0;
      cur_a_r     <= '0;
      cur_b_r     <= '0;
      cur_c_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      lim1_r      <= lim1_nxt;
      lim2_r      <= lim2_nxt;
      lim3_r      <= lim3_nxt;
      cur_a_r     <= cur_a_nxt;
      cur_b_r     <= cur_b_nxt;
      cur_c_r     <= cur_c_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.load) begin
      sample_r <= adc_sample;
      pulse_r  <= (cur_a_r != 8'd0);
      out_a_r  <= cur_a_r;
      out_b_r  <= cur_b_r;
      out_c_r  <= cur_c_r;
    end
    if (cmd.lookup) begin
      sine_r <= QSINE[quo_r];
    end
  end

  assign sts.out_valid = out_valid_r;
  assign sts.lt_one    = phase_r < lim1_r;
  assign sts.lt_two    = phase_r < lim2_r;
  assign sts.lt_three  = phase_r < lim3_r;
  assign sts.div_last  = cnt_r == 3'(DIV_STEPS - 1);

  assign out_valid   = out_valid_r;
  assign pulse_valid = pulse_r;
  assign width_a     = out_a_r;
  assign width_b     = out_b_r;
  assign width_c     = out_c_r;

endmodule
`default_nettype wire

@@ hw/rtl/servo_heartbeat_pattern_sequencer_unit.sv @@
// Servo heartbeat pattern sequencer. Each input transfer is one servo frame
// carrying an 8-bit speed sample; each frame yields one output transfer with
// the three pulse widths set by the previous frame and a pulse flag (set when
// width_a is nonzero). Frames in the swing window run an 8-step restoring
// divider (256*phase/limit_one), a sine table read and a width update, so the
// input is ready again after the divider, lookup and swing states. A wrap
// frame recomputes the three limits one per cycle; frames in the two hold
// windows finish in the transfer cycle. A finished result sits in an output
// register, so the next frame is taken as soon as that result is taken or in
// the same cycle it leaves. Configuration writes are always ready and must
// only be issued while no frame is in flight; unknown indexes are ignored.
`default_nettype none
module servo_heartbeat_pattern_sequencer_unit
  import shps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] adc_sample
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [23:0]             out_tdata,  // [7:0] width_a, [15:8] width_b,
                                              // [23:16] width_c
  output logic                    out_tuser,  // [0] pulse_valid
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]         cfg_data
);

  shps_cmd_t  cmd;
  shps_sts_t  sts;
  logic [7:0] width_a, width_b, width_c;

  assign cfg_ready = 1'b1;

  shps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  shps_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .adc_sample  (in_tdata),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .pulse_valid (out_tuser),
    .width_a     (width_a),
    .width_b     (width_b),
    .width_c     (width_c),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  assign out_tdata = {width_c, width_b, width_a};

  // Every accepted frame leaves a result behind
  a_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after input transfer");

  // Pulse flag agrees with the reported first width
  a_pulse_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[7:0] != 8'd0)))
    else $error("pulse flag disagrees with width_a");

  // Divider only starts inside the swing window
  a_div_in_swing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> sts.lt_one)
    else $error("divider started outside swing window");

  // Divider steps never overlap an input transfer
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_tready)
    else $error("input ready while dividing");

endmodule
`default_nettype wire
